>>> design/ple_pkg.sv
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int ST_W   = 2;

    localparam logic [ACT_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_END   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         length;
    } t_rsp;

    // broadcast to every cell along with the position
    typedef struct packed {
        logic  ins;
        logic  del;
        t_data value;
    } t_cell_ctl;

endpackage

>>> design/ple_cell.sv
module ple_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  ple_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]     i_pos,
    input  ple_pkg::t_data    i_left,
    input  ple_pkg::t_data    i_right,
    output ple_pkg::t_data    o_val,
    output ple_pkg::t_data    o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    ple_pkg::t_data r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                r_val <= i_left;
            end else if (MY_IDX == i_pos) begin
                r_val <= i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                r_val <= i_right;
            end
        end
    end

    assign o_val = r_val;
    assign o_tap = (MY_IDX == i_pos) ? r_val : '0;

endmodule

>>> design/ple_read_tree.sv
module ple_read_tree #(
    parameter int N      = 64,
    parameter int LEVELS = 3
) (
    input  logic           i_clk,
    input  ple_pkg::t_data i_leaf [N],
    output ple_pkg::t_data o_top
);

    localparam int LEAVES = 1 << (2 * LEVELS);

    ple_pkg::t_data w_pad [LEAVES];
    ple_pkg::t_data r_lvl [1:LEVELS][LEAVES];

    for (genvar j = 0; j < LEAVES; j++) begin : g_pad
        if (j < N) begin : g_real
            assign w_pad[j] = i_leaf[j];
        end else begin : g_zero
            assign w_pad[j] = '0;
        end
    end

    // radix-4 OR reduction, one register per level
    for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
        localparam int NODES = LEAVES >> (2 * k);
        for (genvar n = 0; n < NODES; n++) begin : g_node
            if (k == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    r_lvl[k][n] <= w_pad[4*n] | w_pad[4*n+1] | w_pad[4*n+2] | w_pad[4*n+3];
                end
            end else begin : g_upper
                always_ff @(posedge i_clk) begin
                    r_lvl[k][n] <= r_lvl[k-1][4*n] | r_lvl[k-1][4*n+1]
                                 | r_lvl[k-1][4*n+2] | r_lvl[k-1][4*n+3];
                end
            end
        end
    end

    assign o_top = r_lvl[LEVELS][0];

endmodule

>>> design/positional_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// position 0 at the front. Inserts and deletes shift every affected cell in
// parallel; the result for every request other than a successful read is
// registered at the accept edge. A successful read gathers the addressed cell
// through a registered radix-4 OR tree of ceil(log4(CAPACITY)) levels, and the
// block holds off new requests until it is done. A finished result waits in the
// output register, and while it is stalled the next request is held off. Stored
// values are undefined after reset; only the count and the control state are
// cleared. The length field is 7 bits wide.
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ple_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ple_pkg::t_rsp o_rsp
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IW     = $clog2(CAPACITY);
    localparam int CMPW   = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
    localparam int WW     = $clog2(LEVELS + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_busy;
    logic [WW-1:0]       r_wait;
    logic                r_rsp_valid;
    ple_pkg::t_rsp       r_rsp;

    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    logic [CMPW-1:0]     w_cnt_e;
    logic [CMPW-1:0]     w_pos_e;
    logic                w_rd_ok;
    logic [ple_pkg::ST_W-1:0] w_status;
    logic                w_ins;
    logic                w_del;
    logic                w_front;
    logic [IW-1:0]       w_bpos;
    ple_pkg::t_cell_ctl  w_ctl;
    ple_pkg::t_data      w_val [CAPACITY];
    ple_pkg::t_data      w_tap [CAPACITY];
    ple_pkg::t_data      w_top;

    assign w_acc       = i_req_valid && !o_req_stall;
    assign o_req_stall = r_busy || (r_rsp_valid && i_rsp_stall);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_cnt_e     = CMPW'(r_count);
    assign w_pos_e     = CMPW'(i_req.position);

    always_comb begin
        w_rd_ok  = 1'b0;
        w_status = ple_pkg::ST_OK;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_front  = 1'b0;
        n_count  = r_count;
        unique case (i_req.action)
            ple_pkg::ACT_READ: begin
                if (w_pos_e < w_cnt_e) begin
                    w_rd_ok = 1'b1;
                end else begin
                    w_status = ple_pkg::ST_BADPOS;
                end
            end
            ple_pkg::ACT_INS_FRONT: begin
                if (w_full) begin
                    w_status = ple_pkg::ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    w_front = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ple_pkg::ACT_INS_AT: begin
                if (w_full) begin
                    w_status = ple_pkg::ST_FULL;
                end else if (w_pos_e > w_cnt_e) begin
                    w_status = ple_pkg::ST_BADPOS;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ple_pkg::ACT_DEL_FRONT: begin
                if (w_empty) begin
                    w_status = ple_pkg::ST_EMPTY;
                end else begin
                    w_del   = 1'b1;
                    w_front = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ple_pkg::ACT_DEL_END: begin
                if (w_empty) begin
                    w_status = ple_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ple_pkg::ACT_DEL_AT: begin
                if (w_empty) begin
                    w_status = ple_pkg::ST_EMPTY;
                end else if (w_pos_e >= w_cnt_e) begin
                    w_status = ple_pkg::ST_BADPOS;
                end else begin
                    w_del   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                w_status = ple_pkg::ST_BADPOS;
            end
        endcase
    end

    assign w_bpos      = w_front ? '0 : IW'(i_req.position);
    assign w_ctl.ins   = w_acc && w_ins;
    assign w_ctl.del   = w_acc && w_del;
    assign w_ctl.value = i_req.value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ple_pkg::t_data w_left;
        ple_pkg::t_data w_right;
        if (i == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end
        ple_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_bpos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[i]),
            .o_tap   (w_tap[i])
        );
    end

    ple_read_tree #(
        .N      (CAPACITY),
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_top  (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_wait      <= '0;
            r_rsp_valid <= 1'b0;
        end else if (r_busy) begin
            if (r_wait == '0) begin
                r_busy      <= 1'b0;
                r_rsp_valid <= 1'b1;
            end else begin
                r_wait <= r_wait - 1'b1;
            end
        end else if (w_acc) begin
            r_count <= n_count;
            if (w_rd_ok) begin
                r_busy      <= 1'b1;
                r_wait      <= WW'(LEVELS - 1);
                r_rsp_valid <= 1'b0;
            end else begin
                r_rsp_valid <= 1'b1;
            end
        end else if (r_rsp_valid && !i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_wait == '0) begin
                r_rsp.read_value <= w_top;
                r_rsp.status     <= ple_pkg::ST_OK;
                r_rsp.length     <= ple_pkg::POS_W'(r_count);
            end
        end else if (w_acc && !w_rd_ok) begin
            r_rsp.read_value <= '0;
            r_rsp.status     <= w_status;
            r_rsp.length     <= ple_pkg::POS_W'(n_count);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_busy_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_rsp_valid)
        else $error("response pending while a read is in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_quick_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_rd_ok) |=> r_rsp_valid)
        else $error("missing response after request");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("entry count changed without a request");

endmodule

>>> dv/tb_positional_list_engine.sv
`timescale 1ns / 100ps

module tb_positional_list_engine;

    localparam int          LIST_CAP       = 64;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam logic [ple_pkg::ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ple_pkg::ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    ple_pkg::t_req req = '0;
    logic req_stall;
    logic rsp_valid;
    ple_pkg::t_rsp rsp;

    ple_pkg::t_data shadow_list[$];
    ple_pkg::t_rsp  expected_rsp_q[$];
    ple_pkg::t_rsp  exp_rsp;
    int unsigned errors      = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    bit          no_idle     = 1'b0;

    positional_list_engine u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp)
    );

    always #2 clk = ~clk;

    // updates the shadow list and returns the response it should give
    function automatic ple_pkg::t_rsp predict_list_result(input ple_pkg::t_req r);
        ple_pkg::t_rsp res;
        int unsigned   n;
        int unsigned   p;
        n = shadow_list.size();
        p = r.position;
        res = '0;
        res.status = ple_pkg::ST_OK;
        case (r.action)
            ple_pkg::ACT_READ: begin
                if (p < n) res.read_value = shadow_list[p];
                else res.status = ple_pkg::ST_BADPOS;
            end
            ple_pkg::ACT_INS_FRONT: begin
                if (n >= LIST_CAP) res.status = ple_pkg::ST_FULL;
                else shadow_list.push_front(r.value);
            end
            ple_pkg::ACT_INS_AT: begin
                if (n >= LIST_CAP) res.status = ple_pkg::ST_FULL;
                else if (p > n) res.status = ple_pkg::ST_BADPOS;
                else shadow_list.insert(p, r.value);
            end
            ple_pkg::ACT_DEL_FRONT: begin
                if (n == 0) res.status = ple_pkg::ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            ple_pkg::ACT_DEL_END: begin
                if (n == 0) res.status = ple_pkg::ST_EMPTY;
                else void'(shadow_list.pop_back());
            end
            ple_pkg::ACT_DEL_AT: begin
                if (n == 0) res.status = ple_pkg::ST_EMPTY;
                else if (p >= n) res.status = ple_pkg::ST_BADPOS;
                else shadow_list.delete(p);
            end
            default: res.status = ple_pkg::ST_BADPOS;
        endcase
        res.length = ple_pkg::POS_W'(shadow_list.size());
        return res;
    endfunction

    function automatic ple_pkg::t_req mk_req(input logic [ple_pkg::ACT_W-1:0] act,
                                             input ple_pkg::t_data v,
                                             input logic [ple_pkg::POS_W-1:0] pos);
        ple_pkg::t_req r;
        r.action   = act;
        r.value    = v;
        r.position = pos;
        return r;
    endfunction

    // mostly in range, some at or past the end, some anywhere
    function automatic logic [ple_pkg::POS_W-1:0] pick_position();
        int unsigned n;
        int unsigned roll;
        n = shadow_list.size();
        roll = $urandom_range(0, 19);
        if (roll < 16) return ple_pkg::POS_W'($urandom_range(0, n));
        else if (roll < 18) return ple_pkg::POS_W'($urandom_range(0, 127));
        else if (roll == 18) return ple_pkg::POS_W'(n);
        else return ple_pkg::POS_W'(n + 1);
    endfunction

    function automatic ple_pkg::t_req make_req(input int unsigned w_read,
                                               input int unsigned w_ins,
                                               input int unsigned w_del,
                                               input int unsigned w_bad);
        ple_pkg::t_req r;
        int unsigned   roll;
        r.value    = $urandom;
        r.position = pick_position();
        roll = $urandom_range(0, w_read + w_ins + w_del + w_bad - 1);
        if (roll < w_read) begin
            r.action = ple_pkg::ACT_READ;
        end else if (roll < w_read + w_ins) begin
            r.action = $urandom_range(0, 1) ? ple_pkg::ACT_INS_FRONT : ple_pkg::ACT_INS_AT;
        end else if (roll < w_read + w_ins + w_del) begin
            case ($urandom_range(0, 2))
                0: r.action = ple_pkg::ACT_DEL_FRONT;
                1: r.action = ple_pkg::ACT_DEL_END;
                default: r.action = ple_pkg::ACT_DEL_AT;
            endcase
        end else begin
            r.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        end
        return r;
    endfunction

    task automatic send_req(input ple_pkg::t_req r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        expected_rsp_q.push_back(predict_list_result(r));
    endtask

    task automatic wait_settled();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_DEL_FRONT, 32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_DEL_END,   32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_DEL_AT,    32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_INS_AT,    32'sd5, 7'd1));
        send_req(mk_req(ACT_SPARE_6,            32'sd0, 7'd0));
        send_req(mk_req(ACT_SPARE_7,            -32'sd1, 7'd127));
        send_req(mk_req(ple_pkg::ACT_INS_AT,    32'sh8000_0000, 7'd0));
        send_req(mk_req(ple_pkg::ACT_INS_FRONT, 32'sh7fff_ffff, 7'd0));
        send_req(mk_req(ple_pkg::ACT_INS_AT,    -32'sd1, 7'd2));
        send_req(mk_req(ple_pkg::ACT_INS_AT,    32'sd0, 7'd1));
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd3));
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd4));
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd127));
        send_req(mk_req(ple_pkg::ACT_DEL_AT,    32'sd0, 7'd4));
        send_req(mk_req(ple_pkg::ACT_DEL_AT,    32'sd0, 7'd1));
        send_req(mk_req(ple_pkg::ACT_DEL_FRONT, 32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_DEL_END,   32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_READ,      32'sd0, 7'd0));
        send_req(mk_req(ple_pkg::ACT_DEL_END,   32'sd0, 7'd0));
        wait_settled();
    endtask

    task automatic test_random_mix(input int unsigned n_reqs);
        repeat (n_reqs) send_req(make_req(3, 3, 3, 1));
        wait_settled();
    endtask

    // bias the requests to grow the list toward full and back toward empty, twice
    task automatic test_grow_shrink(input int unsigned n_reqs);
        repeat (2) begin
            repeat (n_reqs) send_req(make_req(2, 6, 1, 1));
            repeat (n_reqs) send_req(make_req(2, 1, 6, 1));
        end
        wait_settled();
    endtask

    task automatic test_back_to_back(input int unsigned n_reqs);
        no_idle = 1'b1;
        repeat (n_reqs) send_req(make_req(5, 3, 2, 0));
        wait_settled();
        no_idle = 1'b0;
    endtask

    // response side: random stall, in-order compare
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: response with none expected: %p", $time, rsp);
                    errors++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp.read_value !== exp_rsp.read_value) begin
                        $display("%0t: read_value exp %0d got %0d", $time,
                                 exp_rsp.read_value, rsp.read_value);
                        errors++;
                    end
                    if (rsp.status !== exp_rsp.status) begin
                        $display("%0t: status exp %0d got %0d", $time,
                                 exp_rsp.status, rsp.status);
                        errors++;
                    end
                    if (rsp.length !== exp_rsp.length) begin
                        $display("%0t: length exp %0d got %0d", $time,
                                 exp_rsp.length, rsp.length);
                        errors++;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall_left > 0) begin
                rsp_stall <= 1'b1;
                stall_left--;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[positional_list_engine] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_random_mix(600);
        test_grow_shrink(250);
        test_back_to_back(250);
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_rsp_q.size() == 0) begin
            $display("[positional_list_engine] OK");
        end else begin
            $display("[positional_list_engine] ERROR");
        end
        $finish;
    end

endmodule
